/* design/bcs_pkg.sv */
// ----------------------------------------------------------------------------
// bcs_pkg: shared types and constants of the Bezier curve sampler
// Field widths, operation codes, register codes and lane control bundle.
// ----------------------------------------------------------------------------
package bcs_pkg;

	localparam int MAX_POINTS = 4;
	localparam int OP_W       = 1;
	localparam int IDX_W      = 2;
	localparam int MAXT_W     = 17;
	localparam int SAMPLE_W   = 5;
	localparam int CPC_W      = 3;
	localparam int T_FRAC     = 16;
	localparam int PCNT_W     = 3;
	localparam int LIMIT_BASE = MAXT_W + 1;

	localparam logic [OP_W-1:0]   OP_LOAD    = 1'b0;
	localparam logic [OP_W-1:0]   OP_RUN     = 1'b1;
	localparam logic [CPC_W-1:0]  CPC_RESET  = 3'd4;
	localparam logic [CPC_W-1:0]  CPC_QUAD   = 3'd3;
	localparam logic [PCNT_W-1:0] NPTS_QUAD  = 3'd3;
	localparam logic [PCNT_W-1:0] NPTS_CUBIC = 3'd4;
	localparam logic [MAXT_W:0]   T_MARGIN   = 18'd655;

	typedef struct packed {
		logic clr;
		logic mul;
		logic acc;
		logic prep;
		logic step;
	} lane_ctl_t;

endpackage

/* design/bcs_if.sv */
// ----------------------------------------------------------------------------
// bcs_if: channel interfaces of the Bezier curve sampler
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface bcs_in_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic [bcs_pkg::OP_W-1:0]      operation;
	logic [bcs_pkg::IDX_W-1:0]     point_index;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic signed [COORD_WIDTH-1:0] coord_z;
	logic [bcs_pkg::MAXT_W-1:0]    max_t;

	modport source (
		output valid, operation, point_index, coord_x, coord_y, coord_z, max_t,
		input  ready
	);
	modport sink (
		input  valid, operation, point_index, coord_x, coord_y, coord_z, max_t,
		output ready
	);
endinterface

interface bcs_out_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] out_x;
	logic signed [COORD_WIDTH-1:0] out_y;
	logic signed [COORD_WIDTH-1:0] out_z;
	logic [bcs_pkg::SAMPLE_W-1:0]  sample_number;
	logic                          last;

	modport source (
		output valid, out_x, out_y, out_z, sample_number, last,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_z, sample_number, last,
		output ready
	);
endinterface

interface bcs_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [bcs_pkg::CPC_W-1:0] control_point_count;

	modport source (
		output valid, control_point_count,
		input  ready
	);
	modport sink (
		input  valid, control_point_count,
		output ready
	);
endinterface

/* design/bezier_curve_sampler_core.sv */
// ----------------------------------------------------------------------------
// bezier_curve_sampler_core: quadratic / cubic 3D Bezier curve sampler
// Load items store control points; a run item emits sampled curve points.
// ----------------------------------------------------------------------------
// A load item stores one control point. A run item emits control point 0 from
// S_EMIT0, then each further point k/STEP_COUNT passes through S_WGT1,
// S_WGT2, S_MAC, S_PREP, S_DIV and S_OUT. The multiply-accumulate in each
// coordinate lane walks the control points one a cycle; the divide is a
// single reciprocal multiply in each coordinate lane. A run emits up to
// STEP_COUNT + 1 points, fewer when max_t ends it early, and the next item
// can be taken once it is done. The input is not ready while a run is in
// progress, and the sequencer waits whenever the result register is still
// held by the sink.
// ----------------------------------------------------------------------------
module bezier_curve_sampler_core #(
	parameter int COORD_WIDTH = 16,
	parameter int STEP_COUNT  = 20
) (
	input  logic     clk,
	input  logic     arst_n,
	bcs_cfg_if.sink  cfg,
	bcs_in_if.sink   item,
	bcs_out_if.source result
);
	localparam int KW   = $clog2(STEP_COUNT + 1);
	localparam int KW1  = $clog2(STEP_COUNT + 2);
	localparam int D2   = STEP_COUNT * STEP_COUNT;
	localparam int D3   = STEP_COUNT * STEP_COUNT * STEP_COUNT;
	localparam int DW   = $clog2(D3 + 1);
	localparam int CMPW = bcs_pkg::LIMIT_BASE + KW1;
	localparam logic [COORD_WIDTH-1:0] SGN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EMIT0 = 3'd1;
	localparam logic [2:0] S_WGT1  = 3'd2;
	localparam logic [2:0] S_WGT2  = 3'd3;
	localparam logic [2:0] S_MAC   = 3'd4;
	localparam logic [2:0] S_PREP  = 3'd5;
	localparam logic [2:0] S_DIV   = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [2:0]                     state_q;
	logic [bcs_pkg::CPC_W-1:0]      cpc_q;
	logic [KW-1:0]                  k_q;
	logic [bcs_pkg::PCNT_W-1:0]     jc_q;
	logic [CMPW-1:0]                limit_q;
	logic                           ov_q;
	logic [COORD_WIDTH-1:0]         ox_q;
	logic [COORD_WIDTH-1:0]         oy_q;
	logic [COORD_WIDTH-1:0]         oz_q;
	logic [bcs_pkg::SAMPLE_W-1:0]   osn_q;
	logic                           olast_q;
	logic [COORD_WIDTH-1:0]         cp_q [bcs_pkg::MAX_POINTS][3];

	logic                           item_xfer;
	logic                           cubic;
	logic [bcs_pkg::PCNT_W-1:0]     n_pts;
	logic [KW1-1:0]                 kn;
	logic                           cont;
	logic                           last_c;
	logic                           slot_ok;
	logic                           emit;
	logic [DW-1:0]                  dval;
	bcs_pkg::lane_ctl_t             ctl;
	logic [bcs_pkg::MAX_POINTS-1:0][DW-1:0] w;
	logic [COORD_WIDTH-1:0]         quo [3];

	assign cfg.ready  = 1'b1;
	assign item.ready = (state_q == S_IDLE);

	always_comb begin
		item_xfer = item.valid && item.ready;
		cubic     = (cpc_q != bcs_pkg::CPC_QUAD);
		n_pts     = cubic ? bcs_pkg::NPTS_CUBIC : bcs_pkg::NPTS_QUAD;
		dval      = cubic ? DW'(D3) : DW'(D2);
		kn        = KW1'(k_q) + KW1'(1);
		cont      = (CMPW'(kn) << bcs_pkg::T_FRAC) < limit_q;
		last_c    = (k_q == KW'(STEP_COUNT)) || !cont;
		slot_ok   = !ov_q || result.ready;
		emit      = ((state_q == S_EMIT0) || (state_q == S_OUT)) && slot_ok;
		ctl.clr   = (state_q == S_WGT2);
		ctl.mul   = (state_q == S_MAC) && (jc_q < n_pts);
		ctl.acc   = (state_q == S_MAC) && (jc_q != '0);
		ctl.prep  = (state_q == S_PREP);
		ctl.step  = (state_q == S_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpc_q <= bcs_pkg::CPC_RESET;
		end else if (cfg.valid && cfg.ready) begin
			cpc_q <= cfg.control_point_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			jc_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_xfer && item.operation == bcs_pkg::OP_RUN) begin
						k_q     <= '0;
						state_q <= S_EMIT0;
					end
				end
				S_EMIT0, S_OUT: begin
					if (slot_ok) begin
						if (last_c) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + KW'(1);
							state_q <= S_WGT1;
						end
					end
				end
				S_WGT1: begin
					state_q <= S_WGT2;
				end
				S_WGT2: begin
					jc_q    <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					jc_q <= jc_q + bcs_pkg::PCNT_W'(1);
					if (jc_q == n_pts) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					state_q <= S_OUT;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer && item.operation == bcs_pkg::OP_LOAD) begin
			cp_q[item.point_index][0] <= item.coord_x;
			cp_q[item.point_index][1] <= item.coord_y;
			cp_q[item.point_index][2] <= item.coord_z;
		end
		if (item_xfer && item.operation == bcs_pkg::OP_RUN) begin
			limit_q <= (CMPW'(item.max_t) + CMPW'(bcs_pkg::T_MARGIN)) * CMPW'(STEP_COUNT);
		end
	end

	bcs_weights #(
		.STEP_COUNT (STEP_COUNT)
	) u_weights (
		.clk   (clk),
		.en1   (state_q == S_WGT1),
		.en2   (state_q == S_WGT2),
		.cubic (cubic),
		.k     (k_q),
		.w     (w)
	);

	for (genvar a = 0; a < 3; a++) begin : g_lane
		bcs_lane #(
			.COORD_WIDTH (COORD_WIDTH),
			.STEP_COUNT  (STEP_COUNT)
		) u_lane (
			.clk   (clk),
			.ctl   (ctl),
			.cubic (cubic),
			.coef  (w[jc_q[bcs_pkg::IDX_W-1:0]]),
			.pt    (cp_q[jc_q[bcs_pkg::IDX_W-1:0]][a] ^ SGN),
			.dval  (dval),
			.quo   (quo[a])
		);
	end

	// result register, freed by the sink's transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (state_q == S_EMIT0) begin
				ox_q <= cp_q[0][0];
				oy_q <= cp_q[0][1];
				oz_q <= cp_q[0][2];
			end else begin
				ox_q <= quo[0] ^ SGN;
				oy_q <= quo[1] ^ SGN;
				oz_q <= quo[2] ^ SGN;
			end
			osn_q   <= bcs_pkg::SAMPLE_W'(k_q);
			olast_q <= last_c;
		end
	end

	assign result.valid         = ov_q;
	assign result.out_x         = ox_q;
	assign result.out_y         = oy_q;
	assign result.out_z         = oz_q;
	assign result.sample_number = osn_q;
	assign result.last          = olast_q;

endmodule

/* design/bcs_weights.sv */
// ----------------------------------------------------------------------------
// bcs_weights: Bernstein weight generator
// Two registered stages build the integer weights for step k.
// ----------------------------------------------------------------------------
module bcs_weights #(
	parameter int STEP_COUNT = 20,
	localparam int KW = $clog2(STEP_COUNT + 1),
	localparam int DW = $clog2(STEP_COUNT * STEP_COUNT * STEP_COUNT + 1)
) (
	input  logic                                    clk,
	input  logic                                    en1,
	input  logic                                    en2,
	input  logic                                    cubic,
	input  logic [KW-1:0]                           k,
	output logic [bcs_pkg::MAX_POINTS-1:0][DW-1:0] w
);
	localparam int EW = 3 * KW + 2;

	logic [KW-1:0]     u;
	logic [KW-1:0]     k_s1;
	logic [KW-1:0]     u_s1;
	logic [2*KW-1:0]   k2_s1;
	logic [2*KW-1:0]   u2_s1;
	logic [2*KW-1:0]   ku_s1;
	logic [EW-1:0]     t0;
	logic [EW-1:0]     t1;
	logic [EW-1:0]     t2;
	logic [EW-1:0]     t3;
	logic [bcs_pkg::MAX_POINTS-1:0][DW-1:0] w_s2;

	assign u = KW'(STEP_COUNT) - k;

	always_ff @(posedge clk) begin
		if (en1) begin
			k_s1  <= k;
			u_s1  <= u;
			k2_s1 <= (2*KW)'(k) * (2*KW)'(k);
			u2_s1 <= (2*KW)'(u) * (2*KW)'(u);
			ku_s1 <= (2*KW)'(k) * (2*KW)'(u);
		end
	end

	always_comb begin
		t0 = EW'(u2_s1) * EW'(u_s1);
		t1 = EW'(ku_s1) * EW'(u_s1);
		t2 = EW'(k2_s1) * EW'(u_s1);
		t3 = EW'(k2_s1) * EW'(k_s1);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			w_s2[0] <= cubic ? DW'(t0) : DW'(u2_s1);
			w_s2[1] <= cubic ? DW'((t1 << 1) + t1) : DW'(EW'(ku_s1) << 1);
			w_s2[2] <= cubic ? DW'((t2 << 1) + t2) : DW'(k2_s1);
			w_s2[3] <= cubic ? DW'(t3) : '0;
		end
	end

	assign w = w_s2;

endmodule

/* design/bcs_lane.sv */
// ----------------------------------------------------------------------------
// bcs_lane: one coordinate lane
// Multiply-accumulate over control points, then a rounded divide by the
// curve divisor done as one multiply by its fixed-point reciprocal.
// ----------------------------------------------------------------------------
module bcs_lane #(
	parameter int COORD_WIDTH = 16,
	parameter int STEP_COUNT  = 20,
	localparam int DW = $clog2(STEP_COUNT * STEP_COUNT * STEP_COUNT + 1),
	localparam int AW = COORD_WIDTH + DW,
	localparam int NW = AW + 1
) (
	input  logic                     clk,
	input  bcs_pkg::lane_ctl_t       ctl,
	input  logic                     cubic,
	input  logic [DW-1:0]            coef,
	input  logic [COORD_WIDTH-1:0]   pt,
	input  logic [DW-1:0]            dval,
	output logic [COORD_WIDTH-1:0]   quo
);
	localparam int DIV2 = 2 * STEP_COUNT * STEP_COUNT;
	localparam int DIV3 = 2 * STEP_COUNT * STEP_COUNT * STEP_COUNT;
	localparam int SH2  = NW + $clog2(DIV2);
	localparam int SH3  = NW + $clog2(DIV3);
	localparam int MW   = NW + 1;
	localparam int PW   = NW + MW;
	// ceil(2^SH / divisor): exact floor division for any NW-bit numerator
	localparam logic [MW-1:0] RCP2 = MW'(((128'd1 << SH2) + 128'(DIV2 - 1)) / 128'(DIV2));
	localparam logic [MW-1:0] RCP3 = MW'(((128'd1 << SH3) + 128'(DIV3 - 1)) / 128'(DIV3));

	logic [AW-1:0] prod_q;
	logic [AW-1:0] acc_q;
	logic [NW-1:0] num_q;
	logic [PW-1:0] rprod_q;
	logic [MW-1:0] rcp;

	assign rcp = cubic ? RCP3 : RCP2;

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_q <= AW'(coef) * AW'(pt);
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.acc) begin
			acc_q <= acc_q + prod_q;
		end
		if (ctl.prep) begin
			num_q <= {acc_q, 1'b0} + NW'(dval);
		end
		if (ctl.step) begin
			rprod_q <= PW'(num_q) * PW'(rcp);
		end
	end

	assign quo = cubic ? COORD_WIDTH'(rprod_q >> SH3) : COORD_WIDTH'(rprod_q >> SH2);

endmodule
